>>> rtl/fcull_pkg.sv
// Shared types and constants for the frustum cull test unit.
// Used by fcull_ctrl, fcull_dp and frustum_cull_test_unit; no dependencies.
`timescale 1ns / 1ps
package fcull_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PLANE_COUNT    = 6;
    localparam int CORNER_COUNT   = 8;
    localparam int AXES           = 3;

    // stream layout
    localparam int KIND_W    = 3;
    localparam int S_TDATA_W = 232;
    localparam int M_TDATA_W = 8;
    localparam int FIELD_W   = 32;
    localparam int SLOT_LSB  = 0;
    localparam int AX_LSB    = 3;
    localparam int BX_LSB    = 99;
    localparam int RAD_LSB   = 195;
    localparam int RAD_W     = 31;

    localparam logic [KIND_W-1:0] KIND_LOAD_NORMAL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_CORNER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_EYE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SPHERE_QUERY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BOX_QUERY    = 3'd4;

    // plane and corner slots
    localparam logic [2:0] PL_FAR    = 3'd1;
    localparam logic [2:0] PL_LEFT   = 3'd2;
    localparam logic [2:0] PL_RIGHT  = 3'd3;
    localparam logic [2:0] PL_TOP    = 3'd4;
    localparam logic [2:0] PL_BOTTOM = 3'd5;
    localparam logic [2:0] CN_FTL    = 3'd1;
    localparam logic [2:0] CN_FBR    = 3'd3;

    // step groups of a query
    localparam logic [2:0] SPHERE_LAST_GROUP = 3'd5;
    localparam logic [2:0] BOX_AXIS_GROUP    = 3'd6;
    localparam logic [2:0] SPHERE_EYE_LAST   = 3'd3;
    localparam logic [2:0] SPHERE_PLANE_LAST = 3'd2;
    localparam logic [2:0] BOX_PLANE_LAST    = 3'd5;
    localparam logic [2:0] BOX_HI_FIRST      = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EYE_SQ,
        OP_RAD_SQ,
        OP_SPH_PLANE,
        OP_BOX_LO,
        OP_BOX_HI
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_EYE,
        EV_SPH_PLANE,
        EV_BOX_PLANE,
        EV_AXIS
    } ev_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        op_t        op;
        logic [1:0] axis;
        logic [2:0] plane;
        logic [2:0] corner;
        logic [2:0] dest;
        ev_t        ev;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
    } stat_t;

endpackage

>>> rtl/frustum_cull_test_unit.sv
// Top level of the frustum cull test unit: sequencer plus datapath.
// Depends on fcull_pkg, fcull_ctrl and fcull_dp.
`timescale 1ns / 1ps
// Load items (kind 0..2) fill the plane, corner and eye store and are taken
// back to back while the unit is idle. A sphere or box query holds the unit
// from its accept until its result is emitted to the output register: one
// 33x33 multiplier is shared over all dot products (19 for a sphere, 36 for
// a box, products of min and max face are combined into the eight box
// corners per plane), with the operands and each product registered before
// each plane is judged. One item is worked at a time; a finished result sits
// in the output register while the next item is taken.
module frustum_cull_test_unit
    import fcull_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // kind [2:0]
    input  logic [KIND_W-1:0]    s_tuser,
    // slot [2:0], ax [34:3], ay [66:35], az [98:67], bx [130:99],
    // by [162:131], bz [194:163], sphere_radius [225:195], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // overlaps [0], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t  cmd;
    stat_t stat;
    logic  overlaps;

    fcull_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcull_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .overlaps (overlaps)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, overlaps};

endmodule

>>> rtl/fcull_ctrl.sv
// Sequencer for the frustum cull test unit: handshakes and step commands.
// Depends on fcull_pkg; drives fcull_dp through cmd_t.
`timescale 1ns / 1ps
module fcull_ctrl
    import fcull_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic       is_box_reg, is_box_next;
    logic [2:0] group_reg, group_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [2:0] cnt_last;
    logic       is_query;

    assign is_query = (stat.kind == KIND_SPHERE_QUERY) || (stat.kind == KIND_BOX_QUERY);

    always_comb begin
        if (is_box_reg) begin
            cnt_last = BOX_PLANE_LAST;
        end else if (group_reg == 3'd0) begin
            cnt_last = SPHERE_EYE_LAST;
        end else begin
            cnt_last = SPHERE_PLANE_LAST;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        is_box_next = is_box_reg;
        group_next  = group_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && is_query) begin
                    state_next  = ST_MUL;
                    is_box_next = (stat.kind == KIND_BOX_QUERY);
                    group_next  = 3'd0;
                    cnt_next    = 3'd0;
                end
            end
            ST_MUL: begin
                if (cnt_reg == cnt_last) begin
                    state_next = ST_WAIT;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_WAIT: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if ((is_box_reg && group_reg == BOX_AXIS_GROUP) ||
                    (!is_box_reg && group_reg == SPHERE_LAST_GROUP)) begin
                    state_next = ST_DONE;
                end else begin
                    group_next = group_reg + 3'd1;
                    cnt_next   = 3'd0;
                    // axis group needs no products
                    if (is_box_reg && group_next == BOX_AXIS_GROUP) begin
                        state_next = ST_EVAL;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // take nothing while reset is held
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            ST_MUL: begin
                cmd.dest = cnt_reg;
                if (is_box_reg) begin
                    cmd.plane  = group_reg;
                    cmd.corner = group_reg;
                    if (cnt_reg < BOX_HI_FIRST) begin
                        cmd.op   = OP_BOX_LO;
                        cmd.axis = cnt_reg[1:0];
                    end else begin
                        cmd.op   = OP_BOX_HI;
                        cmd.axis = 2'(cnt_reg - BOX_HI_FIRST);
                    end
                end else if (group_reg == 3'd0) begin
                    cmd.axis = cnt_reg[1:0];
                    cmd.op   = (cnt_reg == SPHERE_EYE_LAST) ? OP_RAD_SQ : OP_EYE_SQ;
                end else begin
                    cmd.op     = OP_SPH_PLANE;
                    cmd.axis   = cnt_reg[1:0];
                    cmd.plane  = group_reg;
                    cmd.corner = (group_reg == PL_RIGHT || group_reg == PL_BOTTOM) ?
                                 CN_FBR : CN_FTL;
                end
            end
            ST_WAIT: begin
            end
            ST_EVAL: begin
                if (is_box_reg) begin
                    cmd.ev = (group_reg == BOX_AXIS_GROUP) ? EV_AXIS : EV_BOX_PLANE;
                end else begin
                    cmd.ev = (group_reg == 3'd0) ? EV_EYE : EV_SPH_PLANE;
                end
            end
            ST_DONE: begin
                cmd.emit = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            is_box_reg   <= 1'b0;
            group_reg    <= 3'd0;
            cnt_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            is_box_reg   <= is_box_next;
            group_reg    <= group_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> rtl/fcull_dp.sv
// Datapath of the frustum cull test unit: vector store, shared multiplier,
// product bank and plane/axis evaluation. Depends on fcull_pkg.
`timescale 1ns / 1ps
module fcull_dp
    import fcull_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [KIND_W-1:0]    s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 overlaps
);

    localparam int MUL_W  = (COORD_BITS + 1 > 32) ? COORD_BITS + 1 : 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;

    // store
    logic signed [COORD_BITS-1:0] nrm_reg [PLANE_COUNT][AXES];
    logic signed [COORD_BITS-1:0] cor_reg [CORNER_COUNT][AXES];
    logic signed [COORD_BITS-1:0] eye_reg [AXES];

    // query
    logic signed [COORD_BITS-1:0] qa_reg [AXES];
    logic signed [COORD_BITS-1:0] qb_reg [AXES];
    logic        [RAD_W-1:0]      rad_reg;

    logic signed [COORD_BITS-1:0] in_a [AXES];
    logic signed [COORD_BITS-1:0] in_b [AXES];
    logic        [2:0]            in_slot;
    logic        [RAD_W-1:0]      in_rad;

    logic signed [MUL_W-1:0]  opa_next, opb_next, opa_reg, opb_reg;
    logic                     mul_v_reg;
    logic        [2:0]        dest_reg;
    logic signed [PROD_W-1:0] prod_reg [2*AXES];

    logic signed [COORD_BITS-1:0] sel_corner, sel_nrm, sel_eye, sel_qa, sel_qb;
    logic signed [MUL_W-1:0]      rad_op;

    logic signed [ACC_W-1:0] sum3, rr, rs, corner_sum;
    logic                    box_all_out, axis_fail, above, below;
    logic                    fail, eye_inside;
    logic                    decided_reg, result_reg, overlaps_reg;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            in_a[k] = s_tdata[AX_LSB + FIELD_W*k +: COORD_BITS];
            in_b[k] = s_tdata[BX_LSB + FIELD_W*k +: COORD_BITS];
        end
    end
    assign in_slot   = s_tdata[SLOT_LSB +: 3];
    assign in_rad    = s_tdata[RAD_LSB +: RAD_W];
    assign stat.kind = s_tuser;

    // operand selection
    assign sel_corner = cor_reg[cmd.corner][cmd.axis];
    assign sel_nrm    = nrm_reg[cmd.plane][cmd.axis];
    assign sel_eye    = eye_reg[cmd.axis];
    assign sel_qa     = qa_reg[cmd.axis];
    assign sel_qb     = qb_reg[cmd.axis];
    assign rad_op     = MUL_W'(signed'({1'b0, rad_reg}));

    always_comb begin
        unique case (cmd.op)
            OP_EYE_SQ: begin
                opa_next = MUL_W'(sel_eye) - MUL_W'(sel_qa);
                opb_next = opa_next;
            end
            OP_RAD_SQ: begin
                opa_next = rad_op;
                opb_next = rad_op;
            end
            OP_SPH_PLANE, OP_BOX_LO: begin
                opa_next = MUL_W'(sel_qa) - MUL_W'(sel_corner);
                opb_next = MUL_W'(sel_nrm);
            end
            OP_BOX_HI: begin
                opa_next = MUL_W'(sel_qb) - MUL_W'(sel_corner);
                opb_next = MUL_W'(sel_nrm);
            end
            default: begin
                opa_next = '0;
                opb_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
        end else begin
            mul_v_reg <= (cmd.op != OP_NONE);
        end
    end

    always_ff @(posedge aclk) begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        dest_reg <= cmd.dest;
        if (mul_v_reg) begin
            prod_reg[dest_reg] <= opa_reg * opb_reg;
        end
    end

    // evaluation over the product bank
    assign sum3 = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2]);
    assign rr   = ACC_W'(prod_reg[3]);
    assign rs   = ACC_W'(signed'({1'b0, rad_reg})) <<< FRAC_BITS;

    always_comb begin
        box_all_out = 1'b1;
        for (int j = 0; j < 8; j++) begin
            corner_sum = ACC_W'(((j & 4) != 0) ? prod_reg[3] : prod_reg[0])
                       + ACC_W'(((j & 2) != 0) ? prod_reg[4] : prod_reg[1])
                       + ACC_W'(((j & 1) != 0) ? prod_reg[5] : prod_reg[2]);
            box_all_out = box_all_out & (corner_sum > 0);
        end
    end

    always_comb begin
        axis_fail = 1'b0;
        for (int k = 0; k < AXES; k++) begin
            above = 1'b1;
            below = 1'b1;
            for (int j = 0; j < CORNER_COUNT; j++) begin
                above = above & (cor_reg[j][k] > qb_reg[k]);
                below = below & (cor_reg[j][k] < qa_reg[k]);
            end
            axis_fail = axis_fail | above | below;
        end
    end

    always_comb begin
        fail       = 1'b0;
        eye_inside = 1'b0;
        unique case (cmd.ev)
            EV_EYE:       eye_inside = !(sum3 > rr);
            EV_SPH_PLANE: fail = (sum3 > rs);
            EV_BOX_PLANE: fail = box_all_out;
            EV_AXIS:      fail = axis_fail;
            default: begin
            end
        endcase
    end

    // loads, query latch, verdict
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            unique case (s_tuser)
                KIND_LOAD_NORMAL: begin
                    if (in_slot < 3'(PLANE_COUNT)) begin
                        nrm_reg[in_slot] <= in_a;
                    end
                end
                KIND_LOAD_CORNER: cor_reg[in_slot] <= in_a;
                KIND_LOAD_EYE:    eye_reg <= in_a;
                KIND_SPHERE_QUERY, KIND_BOX_QUERY: begin
                    qa_reg      <= in_a;
                    qb_reg      <= in_b;
                    rad_reg     <= in_rad;
                    decided_reg <= 1'b0;
                    result_reg  <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (!decided_reg) begin
            if (eye_inside) begin
                decided_reg <= 1'b1;
            end else if (fail) begin
                decided_reg <= 1'b1;
                result_reg  <= 1'b0;
            end
        end
        if (cmd.emit) begin
            overlaps_reg <= result_reg;
        end
    end

    assign overlaps = overlaps_reg;

endmodule

>>> test/testbench.sv
// Testbench for frustum_cull_test_unit: directed table, then random loads and queries.
// Depends on fcull_pkg and the RTL of frustum_cull_test_unit; checks against its own predictor.
`timescale 1ns / 1ps
module testbench;
    import fcull_pkg::*;

    typedef logic [2:0][31:0] vec_t;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  slot;
        vec_t        a;
        vec_t        b;
        logic [30:0] rad;
        int          known; // -1: use predictor, else typed-in overlap bit
    } req_t;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;

    frustum_cull_test_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // predictor copy of the store
    vec_t normals [PLANE_COUNT];
    vec_t corners [CORNER_COUNT];
    vec_t eye_pos;

    bit   overlap_q [$];
    req_t plan_q [$];
    int   errors = 0;
    bit   quiet_phase = 0;

    function automatic logic [31:0] fx(int n);
        return 32'(n) << 16;
    endfunction

    function automatic logic signed [127:0] dot_offset(vec_t p, vec_t q, vec_t n);
        logic signed [127:0] acc, d, m;
        longint dd;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            dd = longint'($signed(p[k])) - longint'($signed(q[k]));
            d = dd;
            m = longint'($signed(n[k]));
            acc = acc + d * m;
        end
        return acc;
    endfunction

    function automatic bit sphere_overlap(vec_t c, logic [30:0] rad);
        logic signed [127:0] d2, d, r, rs;
        longint dd;
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
            dd = longint'($signed(eye_pos[k])) - longint'($signed(c[k]));
            d = dd;
            d2 = d2 + d * d;
        end
        r = {97'd0, rad};
        rs = r <<< 16;
        if (!(d2 > r * r)) return 1;
        if (dot_offset(c, corners[CN_FTL], normals[PL_FAR]) > rs) return 0;
        if (dot_offset(c, corners[CN_FBR], normals[PL_RIGHT]) > rs) return 0;
        if (dot_offset(c, corners[CN_FTL], normals[PL_LEFT]) > rs) return 0;
        if (dot_offset(c, corners[CN_FTL], normals[PL_TOP]) > rs) return 0;
        if (dot_offset(c, corners[CN_FBR], normals[PL_BOTTOM]) > rs) return 0;
        return 1;
    endfunction

    function automatic bit box_overlap(vec_t lo, vec_t hi);
        vec_t v;
        int outside, above, below;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            outside = 0;
            for (int j = 0; j < 8; j++) begin
                v[0] = j[2] ? hi[0] : lo[0];
                v[1] = j[1] ? hi[1] : lo[1];
                v[2] = j[0] ? hi[2] : lo[2];
                if (dot_offset(v, corners[i], normals[i]) > 0) outside++;
            end
            if (outside == 8) return 0;
        end
        for (int k = 0; k < 3; k++) begin
            above = 0;
            below = 0;
            for (int j = 0; j < CORNER_COUNT; j++) begin
                if ($signed(corners[j][k]) > $signed(hi[k])) above++;
                if ($signed(corners[j][k]) < $signed(lo[k])) below++;
            end
            if (above == CORNER_COUNT || below == CORNER_COUNT) return 0;
        end
        return 1;
    endfunction

    // apply an accepted item to the store and queue the overlap bit it causes
    function automatic void apply_item(req_t r);
        bit ov;
        case (r.kind)
            KIND_LOAD_NORMAL: if (r.slot < PLANE_COUNT) normals[r.slot] = r.a;
            KIND_LOAD_CORNER: corners[r.slot] = r.a;
            KIND_LOAD_EYE:    eye_pos = r.a;
            KIND_SPHERE_QUERY, KIND_BOX_QUERY: begin
                ov = (r.kind == KIND_SPHERE_QUERY) ? sphere_overlap(r.a, r.rad)
                                                   : box_overlap(r.a, r.b);
                if (r.known >= 0 && ov != r.known[0]) begin
                    $display("%0t: predictor disagrees with table: expected %0d, actual %0d",
                             $time, r.known, ov);
                    errors++;
                end
                overlap_q.push_back(r.known >= 0 ? r.known[0] : ov);
            end
            default: ;
        endcase
    endfunction

    function automatic int gap_len();
        int p;
        if (quiet_phase) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic void add(logic [2:0] kind, logic [2:0] slot, int ax, int ay, int az,
                                int bx, int by, int bz, logic [30:0] rad, int known);
        req_t r;
        r.kind = kind;
        r.slot = slot;
        r.a = {32'(az), 32'(ay), 32'(ax)};
        r.b = {32'(bz), 32'(by), 32'(bx)};
        r.rad = rad;
        r.known = known;
        plan_q.push_back(r);
    endfunction

    function automatic logic [31:0] rand_coord();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) return fx($urandom_range(0, 80) - 40) + $urandom_range(0, 16'hffff);
        if (p < 90) return $urandom();
        return p[0] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    function automatic req_t rand_item();
        req_t r;
        int p;
        p = $urandom_range(0, 99);
        r.known = -1;
        r.slot = $urandom_range(0, 7);
        for (int k = 0; k < 3; k++) begin
            r.a[k] = rand_coord();
            r.b[k] = rand_coord();
        end
        r.rad = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                            : 31'($urandom_range(0, 32'h0018_0000));
        if (p < 4) r.kind = 3'($urandom_range(5, 7));
        else if (p < 8) r.kind = KIND_LOAD_NORMAL;
        else if (p < 12) r.kind = KIND_LOAD_CORNER;
        else if (p < 14) r.kind = KIND_LOAD_EYE;
        else if (p < 55) r.kind = KIND_SPHERE_QUERY;
        else r.kind = KIND_BOX_QUERY;
        if (r.kind == KIND_LOAD_NORMAL && $urandom_range(0, 1))
            for (int k = 0; k < 3; k++) r.a[k] = fx($urandom_range(0, 2) - 1);
        return r;
    endfunction

    task automatic send(req_t r);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= r.kind;
        s_tdata <= {6'd0, r.rad, r.b[2], r.b[1], r.b[0], r.a[2], r.a[1], r.a[0], r.slot};
        do @(posedge aclk); while (!s_tready);
        apply_item(r);
    endtask

    initial begin
        // box frustum: x,y in [-10,10], z in [1,11], eye at origin
        add(KIND_LOAD_NORMAL, 0, 0, 0, fx(-1), 0, 0, 0, 0, -1);
        add(KIND_LOAD_NORMAL, 1, 0, 0, fx(1), 0, 0, 0, 0, -1);
        add(KIND_LOAD_NORMAL, 2, fx(-1), 0, 0, 0, 0, 0, 0, -1);
        add(KIND_LOAD_NORMAL, 3, fx(1), 0, 0, 0, 0, 0, 0, -1);
        add(KIND_LOAD_NORMAL, 4, 0, fx(1), 0, 0, 0, 0, 0, -1);
        add(KIND_LOAD_NORMAL, 5, 0, fx(-1), 0, 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 0, fx(-10), fx(-10), fx(1), 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 1, fx(-10), fx(10), fx(11), 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 2, fx(-10), fx(-10), fx(11), 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 3, fx(10), fx(-10), fx(11), 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 4, fx(10), fx(10), fx(1), 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 5, fx(10), fx(-10), fx(1), 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 6, fx(-10), fx(10), fx(1), 0, 0, 0, 0, -1);
        add(KIND_LOAD_CORNER, 7, fx(10), fx(10), fx(11), 0, 0, 0, 0, -1);
        add(KIND_LOAD_EYE, 0, 0, 0, 0, 0, 0, 0, 0, -1);
        // eye inside sphere, sphere beyond far plane, sphere inside
        add(KIND_SPHERE_QUERY, 0, 0, 0, 0, 0, 0, 0, 31'(fx(1)), 1);
        add(KIND_SPHERE_QUERY, 0, 0, 0, fx(100), 0, 0, 0, 31'(fx(1)), 0);
        add(KIND_SPHERE_QUERY, 0, 0, 0, fx(5), 0, 0, 0, 31'(fx(1)), 1);
        add(KIND_BOX_QUERY, 0, fx(-1), fx(-1), fx(2), fx(1), fx(1), fx(3), 0, 1);
        add(KIND_BOX_QUERY, 0, fx(20), fx(20), fx(20), fx(30), fx(30), fx(30), 0, 0);
        // extremes, min above max, ignored kinds and normal slot
        add(KIND_SPHERE_QUERY, 7, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            0, 0, 0, 31'h7fffffff, -1);
        add(KIND_BOX_QUERY, 7, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, -1);
        add(KIND_BOX_QUERY, 0, fx(5), fx(5), fx(5), fx(-5), fx(-5), fx(2), 0, -1);
        add(3'd5, 0, -1, -1, -1, -1, -1, -1, 31'h7fffffff, -1);
        add(3'd7, 7, 0, 0, 0, 0, 0, 0, 0, -1);
        add(KIND_LOAD_NORMAL, 7, -1, -1, -1, 0, 0, 0, 0, -1);
        add(KIND_SPHERE_QUERY, 0, 0, 0, fx(5), 0, 0, 0, 31'(fx(1)), 1);

        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (plan_q[i]) send(plan_q[i]);
        for (int n = 0; n < 650; n++) begin
            if (n % 50 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
            send(rand_item());
        end
        s_tvalid <= 0;
        while (overlap_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && overlap_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // result side stalls
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (overlap_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, m_tdata[0]);
                errors++;
            end else begin
                if (m_tdata[0] !== overlap_q[0] || m_tdata[M_TDATA_W-1:1] !== '0) begin
                    $display("%0t: overlaps mismatch, expected %0d, actual %h",
                             $time, overlap_q[0], m_tdata);
                    errors++;
                end
                void'(overlap_q.pop_front());
            end
        end
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/fcull_pkg.sv
rtl/fcull_ctrl.sv
rtl/fcull_dp.sv
rtl/frustum_cull_test_unit.sv
test/testbench.sv
